[hdl/cfp_pkg.sv]
// Shared types and constants for the configuration frame parser.
// No dependencies; the stream interface and the parser refer to it by scoped names.
package cfp_pkg;

    // default sizes for the top level parameters
    localparam int LAYER_COUNT_DEF  = 8;
    localparam int BUTTON_COUNT_DEF = 16;
    localparam int BINDING_MAX_DEF  = 16;
    localparam int LABEL_MAX_DEF    = 16;

    // frame marks and the layer mode code
    localparam logic [7:0] START_MARK = 8'h01;
    localparam logic [7:0] LABEL_MARK = 8'h02;
    localparam logic [7:0] END_MARK   = 8'h03;
    localparam logic [7:0] LAYER_MODE = 8'h02;

    // result kinds
    localparam logic [2:0] KIND_FAIL    = 3'd0;
    localparam logic [2:0] KIND_HEADER  = 3'd1;
    localparam logic [2:0] KIND_BINDING = 3'd2;
    localparam logic [2:0] KIND_LABEL   = 3'd3;
    localparam logic [2:0] KIND_STYLE   = 3'd4;
    localparam logic [2:0] KIND_SUCCESS = 3'd5;

    // width of field lengths and positions
    localparam int LEN_W = 5;

    // parse phases followed by the emit sequence
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LAYER,
        ST_KEY,
        ST_MODE,
        ST_BIND,
        ST_LABEL,
        ST_RED,
        ST_GREEN,
        ST_BLUE,
        ST_END,
        ST_BIND_RD,
        ST_BIND_OUT,
        ST_LABEL_RD,
        ST_LABEL_OUT,
        ST_SUCCESS
    } state_t;

    // input item
    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_item_t;

    // result item
    typedef struct packed {
        logic [2:0]       kind;
        logic [2:0]       layer_index;
        logic [4:0]       key_index;
        logic [7:0]       mode_byte;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] position;
        logic [LEN_W-1:0] label_count;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [2:0]       highest_layer;
        logic             last;
    } result_t;

endpackage

[hdl/cfp_stream_if.sv]
// Valid/ready channel carrying one item of a given payload type.
// Payload types come from cfp_pkg.
interface cfp_stream_if #(
    parameter type payload_t = cfp_pkg::rx_item_t
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/config_frame_parser.sv]
// Configuration frame parser: one received byte per item, results on a registered output.
// A byte that completes no frame is taken when the output is free; a fail result shows the cycle after.
// A finished key frame gives its header in the cycle after END, then each buffered byte
// (RAM read state, then output load state, which waits for a free output), then the success
// item, holding input off meanwhile; a style frame holds input off in the success state.
// Reset (rst_n low, asynchronous) returns to the start-byte wait with no output pending.
module config_frame_parser #(
    parameter int LAYER_COUNT  = cfp_pkg::LAYER_COUNT_DEF,
    parameter int BUTTON_COUNT = cfp_pkg::BUTTON_COUNT_DEF,
    parameter int BINDING_MAX  = cfp_pkg::BINDING_MAX_DEF,
    parameter int LABEL_MAX    = cfp_pkg::LABEL_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cfp_stream_if.sink rx,
    cfp_stream_if.source res
);

    localparam int BIND_AW = (BINDING_MAX > 1) ? $clog2(BINDING_MAX) : 1;
    localparam int LABEL_AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
    localparam logic [8:0] LAYER_LIM = 9'(LAYER_COUNT);
    localparam logic [7:0] KEY_LIM = 8'(BUTTON_COUNT);
    localparam logic [4:0] STYLE_KEY = 5'(BUTTON_COUNT % 32);
    localparam logic [cfp_pkg::LEN_W-1:0] BIND_LIM = cfp_pkg::LEN_W'(BINDING_MAX);
    localparam logic [cfp_pkg::LEN_W-1:0] LABEL_LIM = cfp_pkg::LEN_W'(LABEL_MAX);

    cfp_pkg::state_t state_reg, state_next;
    logic [2:0]  frame_layer_reg, frame_layer_next;
    logic [4:0]  frame_key_reg, frame_key_next;
    logic [7:0]  frame_mode_reg, frame_mode_next;
    logic [cfp_pkg::LEN_W-1:0] bind_len_reg, bind_len_next;
    logic [cfp_pkg::LEN_W-1:0] label_len_reg, label_len_next;
    logic [cfp_pkg::LEN_W-1:0] emit_idx_reg, emit_idx_next;
    logic [23:0] colour_reg, colour_next;
    logic [2:0]  top_layer_reg, top_layer_next;
    logic        out_valid_reg, out_valid_next;
    cfp_pkg::result_t out_data_reg, out_data_next;

    logic [7:0] x;
    logic       parse_st;
    logic       out_free;
    logic       accept;
    logic       bind_take;
    logic [cfp_pkg::LEN_W-1:0] idx_inc;
    logic       bind_we, label_we;
    logic [7:0] bind_rdata, label_rdata;
    cfp_pkg::result_t fail_res;
    cfp_pkg::result_t item_res;

    // buffered field bytes
    cfp_ram #(.WIDTH(8), .DEPTH(BINDING_MAX)) u_bind_ram (
        .clk   (clk),
        .we    (bind_we),
        .waddr (bind_len_reg[BIND_AW-1:0]),
        .wdata (x),
        .raddr (emit_idx_reg[BIND_AW-1:0]),
        .rdata (bind_rdata)
    );

    cfp_ram #(.WIDTH(8), .DEPTH(LABEL_MAX)) u_label_ram (
        .clk   (clk),
        .we    (label_we),
        .waddr (label_len_reg[LABEL_AW-1:0]),
        .wdata (x),
        .raddr (emit_idx_reg[LABEL_AW-1:0]),
        .rdata (label_rdata)
    );

    // handshake and shared terms
    assign x        = rx.data.rx_byte;
    assign parse_st = (state_reg == cfp_pkg::ST_IDLE)  || (state_reg == cfp_pkg::ST_LAYER) ||
                      (state_reg == cfp_pkg::ST_KEY)   || (state_reg == cfp_pkg::ST_MODE)  ||
                      (state_reg == cfp_pkg::ST_BIND)  || (state_reg == cfp_pkg::ST_LABEL) ||
                      (state_reg == cfp_pkg::ST_RED)   || (state_reg == cfp_pkg::ST_GREEN) ||
                      (state_reg == cfp_pkg::ST_BLUE)  || (state_reg == cfp_pkg::ST_END);
    assign out_free = !out_valid_reg || res.ready;
    assign rx.ready = parse_st && out_free;
    assign accept   = rx.valid && rx.ready;
    assign bind_take = (x != cfp_pkg::LABEL_MARK) ||
                       ((bind_len_reg == '0) && (frame_mode_reg == cfp_pkg::LAYER_MODE));
    assign idx_inc  = emit_idx_reg + cfp_pkg::LEN_W'(1);

    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cfp_pkg::ST_IDLE:
            begin
                if (accept && (x == cfp_pkg::START_MARK))
                begin
                    state_next = cfp_pkg::ST_LAYER;
                end
            end
            cfp_pkg::ST_LAYER:
            begin
                if (accept)
                begin
                    state_next = ({1'b0, x} < LAYER_LIM) ? cfp_pkg::ST_KEY : cfp_pkg::ST_IDLE;
                end
            end
            cfp_pkg::ST_KEY:
            begin
                if (accept)
                begin
                    state_next = (x <= KEY_LIM) ? cfp_pkg::ST_MODE : cfp_pkg::ST_IDLE;
                end
            end
            cfp_pkg::ST_MODE:
            begin
                if (accept)
                begin
                    state_next = (frame_key_reg == STYLE_KEY) ? cfp_pkg::ST_RED
                                                               : cfp_pkg::ST_BIND;
                end
            end
            cfp_pkg::ST_BIND:
            begin
                if (accept)
                begin
                    if (!bind_take)
                    begin
                        state_next = cfp_pkg::ST_LABEL;
                    end
                    else if (bind_len_reg >= BIND_LIM)
                    begin
                        state_next = cfp_pkg::ST_IDLE;
                    end
                end
            end
            cfp_pkg::ST_LABEL:
            begin
                if (accept)
                begin
                    if (x == cfp_pkg::END_MARK)
                    begin
                        if (bind_len_reg != '0)
                        begin
                            state_next = cfp_pkg::ST_BIND_RD;
                        end
                        else if (label_len_reg != '0)
                        begin
                            state_next = cfp_pkg::ST_LABEL_RD;
                        end
                        else
                        begin
                            state_next = cfp_pkg::ST_SUCCESS;
                        end
                    end
                    else if (label_len_reg >= LABEL_LIM)
                    begin
                        state_next = cfp_pkg::ST_IDLE;
                    end
                end
            end
            cfp_pkg::ST_RED:
            begin
                if (accept)
                begin
                    state_next = cfp_pkg::ST_GREEN;
                end
            end
            cfp_pkg::ST_GREEN:
            begin
                if (accept)
                begin
                    state_next = cfp_pkg::ST_BLUE;
                end
            end
            cfp_pkg::ST_BLUE:
            begin
                if (accept)
                begin
                    state_next = cfp_pkg::ST_END;
                end
            end
            cfp_pkg::ST_END:
            begin
                if (accept)
                begin
                    state_next = (x == cfp_pkg::END_MARK) ? cfp_pkg::ST_SUCCESS
                                                           : cfp_pkg::ST_IDLE;
                end
            end
            cfp_pkg::ST_BIND_RD:
            begin
                state_next = cfp_pkg::ST_BIND_OUT;
            end
            cfp_pkg::ST_BIND_OUT:
            begin
                if (out_free)
                begin
                    if (idx_inc < bind_len_reg)
                    begin
                        state_next = cfp_pkg::ST_BIND_RD;
                    end
                    else if (label_len_reg != '0)
                    begin
                        state_next = cfp_pkg::ST_LABEL_RD;
                    end
                    else
                    begin
                        state_next = cfp_pkg::ST_SUCCESS;
                    end
                end
            end
            cfp_pkg::ST_LABEL_RD:
            begin
                state_next = cfp_pkg::ST_LABEL_OUT;
            end
            cfp_pkg::ST_LABEL_OUT:
            begin
                if (out_free)
                begin
                    state_next = (idx_inc < label_len_reg) ? cfp_pkg::ST_LABEL_RD
                                                            : cfp_pkg::ST_SUCCESS;
                end
            end
            cfp_pkg::ST_SUCCESS:
            begin
                if (out_free)
                begin
                    state_next = cfp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfp_pkg::ST_IDLE;
            end
        endcase
    end

    // frame registers, buffer writes and result loads
    always_comb
    begin
        frame_layer_next = frame_layer_reg;
        frame_key_next   = frame_key_reg;
        frame_mode_next  = frame_mode_reg;
        bind_len_next    = bind_len_reg;
        label_len_next   = label_len_reg;
        emit_idx_next    = emit_idx_reg;
        colour_next      = colour_reg;
        top_layer_next   = top_layer_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_data_next    = out_data_reg;
        bind_we          = 1'b0;
        label_we         = 1'b0;

        fail_res               = '0;
        fail_res.kind          = cfp_pkg::KIND_FAIL;
        fail_res.highest_layer = top_layer_reg;
        fail_res.last          = 1'b1;

        item_res               = '0;
        item_res.layer_index   = frame_layer_reg;
        item_res.key_index     = frame_key_reg;
        item_res.position      = emit_idx_reg;
        item_res.highest_layer = top_layer_reg;

        case (state_reg)
            cfp_pkg::ST_IDLE:
            begin
                if (accept && (x != cfp_pkg::START_MARK))
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = fail_res;
                end
            end
            cfp_pkg::ST_LAYER:
            begin
                if (accept)
                begin
                    if ({1'b0, x} < LAYER_LIM)
                    begin
                        frame_layer_next = x[2:0];
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = fail_res;
                    end
                end
            end
            cfp_pkg::ST_KEY:
            begin
                if (accept)
                begin
                    if (x <= KEY_LIM)
                    begin
                        frame_key_next = x[4:0];
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = fail_res;
                    end
                end
            end
            cfp_pkg::ST_MODE:
            begin
                if (accept)
                begin
                    frame_mode_next = x;
                    if (frame_key_reg != STYLE_KEY)
                    begin
                        bind_len_next = '0;
                    end
                end
            end
            cfp_pkg::ST_BIND:
            begin
                if (accept)
                begin
                    if (!bind_take)
                    begin
                        label_len_next = '0;
                    end
                    else if (bind_len_reg >= BIND_LIM)
                    begin
                        bind_len_next  = '0;
                        out_valid_next = 1'b1;
                        out_data_next  = fail_res;
                    end
                    else
                    begin
                        bind_we       = 1'b1;
                        bind_len_next = bind_len_reg + cfp_pkg::LEN_W'(1);
                    end
                end
            end
            cfp_pkg::ST_LABEL:
            begin
                if (accept)
                begin
                    if (x == cfp_pkg::END_MARK)
                    begin
                        // key frame done: raise top layer, show header
                        if (frame_layer_reg > top_layer_reg)
                        begin
                            top_layer_next = frame_layer_reg;
                        end
                        out_valid_next              = 1'b1;
                        out_data_next               = item_res;
                        out_data_next.kind          = cfp_pkg::KIND_HEADER;
                        out_data_next.mode_byte     = frame_mode_reg;
                        out_data_next.position      = bind_len_reg;
                        out_data_next.label_count   = label_len_reg;
                        out_data_next.highest_layer = top_layer_next;
                        emit_idx_next               = '0;
                    end
                    else if (label_len_reg >= LABEL_LIM)
                    begin
                        bind_len_next  = '0;
                        label_len_next = '0;
                        out_valid_next = 1'b1;
                        out_data_next  = fail_res;
                    end
                    else
                    begin
                        label_we       = 1'b1;
                        label_len_next = label_len_reg + cfp_pkg::LEN_W'(1);
                    end
                end
            end
            cfp_pkg::ST_RED:
            begin
                if (accept)
                begin
                    colour_next[23:16] = x;
                end
            end
            cfp_pkg::ST_GREEN:
            begin
                if (accept)
                begin
                    colour_next[15:8] = x;
                end
            end
            cfp_pkg::ST_BLUE:
            begin
                if (accept)
                begin
                    colour_next[7:0] = x;
                end
            end
            cfp_pkg::ST_END:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    if (x == cfp_pkg::END_MARK)
                    begin
                        out_data_next           = item_res;
                        out_data_next.kind      = cfp_pkg::KIND_STYLE;
                        out_data_next.mode_byte = frame_mode_reg;
                        out_data_next.position  = '0;
                        out_data_next.red       = colour_reg[23:16];
                        out_data_next.green     = colour_reg[15:8];
                        out_data_next.blue      = colour_reg[7:0];
                    end
                    else
                    begin
                        out_data_next = fail_res;
                    end
                end
            end
            cfp_pkg::ST_BIND_OUT:
            begin
                // read data for emit_idx arrived in the read state
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next           = item_res;
                    out_data_next.kind      = cfp_pkg::KIND_BINDING;
                    out_data_next.data_byte = bind_rdata;
                    emit_idx_next = (idx_inc < bind_len_reg) ? idx_inc : '0;
                end
            end
            cfp_pkg::ST_LABEL_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next           = item_res;
                    out_data_next.kind      = cfp_pkg::KIND_LABEL;
                    out_data_next.data_byte = label_rdata;
                    emit_idx_next           = idx_inc;
                end
            end
            cfp_pkg::ST_SUCCESS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = fail_res;
                    out_data_next.kind = cfp_pkg::KIND_SUCCESS;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cfp_pkg::ST_IDLE;
            frame_layer_reg <= '0;
            frame_key_reg   <= '0;
            frame_mode_reg  <= '0;
            bind_len_reg    <= '0;
            label_len_reg   <= '0;
            emit_idx_reg    <= '0;
            colour_reg      <= '0;
            top_layer_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            frame_layer_reg <= frame_layer_next;
            frame_key_reg   <= frame_key_next;
            frame_mode_reg  <= frame_mode_next;
            bind_len_reg    <= bind_len_next;
            label_len_reg   <= label_len_next;
            emit_idx_reg    <= emit_idx_next;
            colour_reg      <= colour_next;
            top_layer_reg   <= top_layer_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

[hdl/cfp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module cfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
